// ===== sv/bmo_pkg.sv =====
// Shared constants and types for the 3x3 binary opening block.
`default_nettype none
package bmo_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam logic [7:0] MARK_HIGH = 8'd255;
   localparam logic [7:0] MARK_LOW  = 8'd0;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PASS_COUNT   = 2'd2;

   localparam logic [8:0] FRAME_WIDTH_RST  = 9'd256;
   localparam logic [8:0] FRAME_HEIGHT_RST = 9'd256;
   localparam logic [7:0] PASS_COUNT_RST   = 8'd1;

   // Pass engine status towards the top level
   typedef struct packed {
      logic busy;
      logic flip;
   } eng_status_type;

endpackage
`default_nettype wire

// ===== sv/bmo_bank.sv =====
// One frame memory: one write port, one read port with registered read data.
`default_nettype none
module bmo_bank #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/bmo_engine.sv =====
// Pass sequencer: walks the frame, reads each 3x3 window from the source bank, writes the result.
`default_nettype none
module bmo_engine #(
   parameter int MAX_WIDTH  = bmo_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmo_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]         width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]        height,
   input  wire logic [7:0]                             pass_count,
   input  wire logic [7:0]                             src_data,
   output logic [((MAX_WIDTH*MAX_HEIGHT > 1) ?
                  $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0] rd_addr,
   output logic                                        wr_en,
   output logic [((MAX_WIDTH*MAX_HEIGHT > 1) ?
                  $clog2(MAX_WIDTH*MAX_HEIGHT) : 1)-1:0] wr_addr,
   output logic [7:0]                                  wr_data,
   output bmo_pkg::eng_status_type                     status
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EW    = ((AW > DW) ? AW : DW) + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   // window step -> row and column offset (0 = minus one, 1 = centre, 2 = plus one)
   function automatic logic [3:0] win_offset(input logic [3:0] k);
      logic [3:0] res;
      case (k)
         4'd0:    res = {2'd0, 2'd0};
         4'd1:    res = {2'd0, 2'd1};
         4'd2:    res = {2'd0, 2'd2};
         4'd3:    res = {2'd1, 2'd0};
         4'd4:    res = {2'd1, 2'd1};
         4'd5:    res = {2'd1, 2'd2};
         4'd6:    res = {2'd2, 2'd0};
         4'd7:    res = {2'd2, 2'd1};
         4'd8:    res = {2'd2, 2'd2};
         default: res = {2'd1, 2'd1};
      endcase
      return res;
   endfunction

   localparam logic [3:0] STEP_CENTRE = 4'd4;
   localparam logic [3:0] STEP_LAST   = 4'd8;
   localparam logic [3:0] STEP_WRITE  = 4'd9;

   state_type   state_ff, state_in;
   logic [3:0]  k_ff, k_in;
   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;
   logic [AW-1:0] base_ff, base_in;
   logic [8:0]  pass_ff, pass_in;
   logic        hit_ff, hit_in;
   logic        iss_ff, iss_in;
   logic        ctr_ff, ctr_in;
   logic [7:0]  centre_ff, centre_in;

   logic        run;
   logic        issue;
   logic [7:0]  mark;
   logic [8:0]  total;
   logic        r_last, c_last, last_pix;
   logic [1:0]  ky, kx;
   logic [EW-1:0] base_e, width_e, row_sel;
   logic [CW-1:0] col_sel;
   logic        hit_all;

   assign run      = (state_ff == ST_RUN);
   assign issue    = run && (k_ff <= STEP_LAST);
   assign total    = {pass_count, 1'b0};
   assign mark     = (pass_ff < {1'b0, pass_count}) ? bmo_pkg::MARK_HIGH : bmo_pkg::MARK_LOW;
   assign r_last   = (HW'(r_ff) == (height - HW'(1)));
   assign c_last   = (DW'(c_ff) == (width - DW'(1)));
   assign last_pix = r_last && c_last;
   assign {ky, kx} = win_offset(k_ff);
   assign base_e   = EW'(base_ff);
   assign width_e  = EW'(width);

   always_comb begin
      case (ky)
         2'd0:    row_sel = (r_ff != '0) ? (base_e - width_e) : base_e;
         2'd2:    row_sel = (!r_last) ? (base_e + width_e) : base_e;
         default: row_sel = base_e;
      endcase
      case (kx)
         2'd0:    col_sel = (c_ff != '0) ? (c_ff - CW'(1)) : c_ff;
         2'd2:    col_sel = (!c_last) ? (c_ff + CW'(1)) : c_ff;
         default: col_sel = c_ff;
      endcase
   end

   assign rd_addr = AW'(row_sel + EW'(col_sel));
   assign hit_all = hit_ff || (iss_ff && (src_data == mark));

   assign wr_en   = run && (k_ff == STEP_WRITE);
   assign wr_addr = AW'(base_e + EW'(c_ff));
   assign wr_data = hit_all ? mark : centre_ff;

   assign status.busy = run;
   assign status.flip = run && (k_ff == STEP_WRITE) && last_pix;

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      base_in   = base_ff;
      pass_in   = pass_ff;
      hit_in    = hit_ff;
      centre_in = centre_ff;
      iss_in    = issue;
      ctr_in    = issue && (k_ff == STEP_CENTRE);
      case (state_ff)
         ST_IDLE: begin
            if (start && (pass_count != '0)) begin
               state_in = ST_RUN;
               k_in     = '0;
               r_in     = '0;
               c_in     = '0;
               base_in  = '0;
               pass_in  = '0;
               hit_in   = 1'b0;
            end
         end
         ST_RUN: begin
            if (ctr_ff) begin
               centre_in = src_data;
            end
            if (k_ff != STEP_WRITE) begin
               k_in   = k_ff + 4'd1;
               hit_in = hit_all;
            end else begin
               k_in   = '0;
               hit_in = 1'b0;
               if (!c_last) begin
                  c_in = c_ff + CW'(1);
               end else begin
                  c_in = '0;
                  if (!r_last) begin
                     r_in    = r_ff + RW'(1);
                     base_in = AW'(base_e + width_e);
                  end else begin
                     r_in    = '0;
                     base_in = '0;
                     pass_in = pass_ff + 9'd1;
                     if ((pass_ff + 9'd1) == total) begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         base_ff  <= '0;
         pass_ff  <= '0;
         hit_ff   <= 1'b0;
         iss_ff   <= 1'b0;
         ctr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         base_ff  <= base_in;
         pass_ff  <= pass_in;
         hit_ff   <= hit_in;
         iss_ff   <= iss_in;
         ctr_ff   <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      centre_ff <= centre_in;
   end

endmodule
`default_nettype wire

// ===== sv/binary_morph_open_3x3.sv =====
// Top level of the 3x3 binary opening block: load/read control, bank select, memories.
//
// Frames are loaded one pixel per beat in raster order; a load is taken every cycle. A read
// beat is not taken while an earlier read is still pending at the single registered read
// port or while the output holds a beat not yet taken. The beat that loads the last pixel
// starts 2 * pass_count passes (dilate by 255, then erode by 0); each pass takes nine
// window reads and one write slot per pixel through the source bank's one read port, and
// no beat is taken meanwhile. The two banks swap roles after every pass. Memories need no
// clearing after reset; reading pixels never loaded returns undefined data.
`default_nettype none
module binary_morph_open_3x3 #(
   parameter int MAX_WIDTH  = bmo_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bmo_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_pixel_in,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_pixel_out,
   output logic            rsp_frame_end,
   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int SW    = $clog2(DEPTH + 1);

   logic [8:0] width_ff, height_ff;
   logic [7:0] pass_ff;
   logic [AW-1:0] load_pos_ff, load_pos_in;
   logic [AW-1:0] read_pos_ff, read_pos_in;
   logic bank_ff;
   logic rd_pend_ff;
   logic rd_end_ff, rd_end_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff;
   logic rsp_end_ff;

   logic [DW-1:0] width_c;
   logic [HW-1:0] height_c;
   logic [SW-1:0] size, lpos, rpos;
   logic accept, is_load, load_we, read_acc, load_last, start;
   logic [AW-1:0] top_rd_addr, rd_addr;
   logic [7:0] rd_data0, rd_data1, src_data;
   logic [AW-1:0] eng_rd_addr, eng_wr_addr;
   logic eng_wr_en;
   logic [7:0] eng_wr_data;
   bmo_pkg::eng_status_type eng_status;
   logic we0, we1;
   logic [AW-1:0] wa0, wa1;
   logic [7:0] wd0, wd1;

   // size clamp: zero counts as one, above maximum saturates
   always_comb begin
      if (width_ff == '0) begin
         width_c = DW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_c = DW'(MAX_WIDTH);
      end else begin
         width_c = DW'(width_ff);
      end
      if (height_ff == '0) begin
         height_c = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_c = HW'(MAX_HEIGHT);
      end else begin
         height_c = HW'(height_ff);
      end
   end

   assign size = SW'(SW'(width_c) * SW'(height_c));

   assign req_ready = !eng_status.busy &&
                      ((req_operation == bmo_pkg::OP_LOAD) ||
                       (!rd_pend_ff && (!rsp_valid_ff || rsp_ready)));
   assign accept    = req_valid && req_ready;
   assign is_load   = (req_operation == bmo_pkg::OP_LOAD);
   assign load_we   = accept && is_load;
   assign read_acc  = accept && !is_load;

   assign lpos      = (SW'(load_pos_ff) >= size) ? (size - SW'(1)) : SW'(load_pos_ff);
   assign load_last = (lpos == (size - SW'(1)));
   assign start     = load_we && load_last;
   assign rpos      = (SW'(read_pos_ff) >= size) ? '0 : SW'(read_pos_ff);
   assign top_rd_addr = AW'(rpos);

   always_comb begin
      load_pos_in = load_pos_ff;
      read_pos_in = read_pos_ff;
      rd_end_in   = rd_end_ff;
      if (load_we) begin
         if (load_last) begin
            load_pos_in = '0;
            read_pos_in = '0;
         end else begin
            load_pos_in = AW'(lpos + SW'(1));
         end
      end
      if (read_acc) begin
         rd_end_in   = (rpos == (size - SW'(1)));
         read_pos_in = ((rpos + SW'(1)) >= size) ? '0 : AW'(rpos + SW'(1));
      end
   end

   assign rsp_valid_in = rd_pend_ff || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bmo_pkg::FRAME_WIDTH_RST;
         height_ff    <= bmo_pkg::FRAME_HEIGHT_RST;
         pass_ff      <= bmo_pkg::PASS_COUNT_RST;
         load_pos_ff  <= '0;
         read_pos_ff  <= '0;
         bank_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               bmo_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data;
               bmo_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data;
               bmo_pkg::CSR_PASS_COUNT:   pass_ff   <= csr_data[7:0];
               default: ;
            endcase
         end
         load_pos_ff  <= load_pos_in;
         read_pos_ff  <= read_pos_in;
         if (eng_status.flip) begin
            bank_ff <= !bank_ff;
         end
         rd_pend_ff   <= read_acc;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_end_ff <= rd_end_in;
      if (rd_pend_ff) begin
         rsp_pixel_ff <= src_data;
         rsp_end_ff   <= rd_end_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_frame_end = rsp_end_ff;

   // bank_ff selects the source: loads and reads use it, the engine writes the other one
   assign src_data = bank_ff ? rd_data1 : rd_data0;
   assign rd_addr  = eng_status.busy ? eng_rd_addr : top_rd_addr;

   always_comb begin
      we0 = bank_ff ? eng_wr_en : load_we;
      we1 = bank_ff ? load_we : eng_wr_en;
      wa0 = bank_ff ? eng_wr_addr : AW'(lpos);
      wa1 = bank_ff ? AW'(lpos) : eng_wr_addr;
      wd0 = bank_ff ? eng_wr_data : req_pixel_in;
      wd1 = bank_ff ? req_pixel_in : eng_wr_data;
   end

   bmo_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (wa0),
      .wr_data (wd0),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   bmo_bank #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (wa1),
      .wr_data (wd1),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   bmo_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .width      (width_c),
      .height     (height_c),
      .pass_count (pass_ff),
      .src_data   (src_data),
      .rd_addr    (eng_rd_addr),
      .wr_en      (eng_wr_en),
      .wr_addr    (eng_wr_addr),
      .wr_data    (eng_wr_data),
      .status     (eng_status)
   );

   // no beat taken while a pass runs
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      eng_status.busy |-> !req_ready)
      else $error("request taken during a pass");

   // read data lands in an empty output register and is shown next cycle
   a_pend_slot: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !rsp_valid_ff)
      else $error("read data would overwrite a waiting beat");

   a_pend_out: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_valid_ff)
      else $error("read data lost");

   // banks swap only at the end of a running pass, which keeps the engine busy that cycle
   a_flip_busy: assert property (@(posedge clock) disable iff (reset)
      eng_status.flip |-> (eng_status.busy && eng_wr_en))
      else $error("bank swap outside a pass");

endmodule
`default_nettype wire
